// ===== hw/rtl/y2r_pkg.sv =====
// Shared constants and types for the YUYV to RGB565 crop unit.
package y2r_pkg;

    // Stream payload widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;
    localparam int IDX_W     = 22;
    localparam int PIX_W     = 16;

    // Configuration port
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int SIZE_W    = 12;
    localparam int OFS_W     = 8;

    typedef enum logic [2:0] {
        REG_CAMERA_WIDTH   = 3'd0,
        REG_CAMERA_HEIGHT  = 3'd1,
        REG_DISPLAY_WIDTH  = 3'd2,
        REG_DISPLAY_HEIGHT = 3'd3,
        REG_CHROMA_V_OFS   = 3'd4
    } cfg_reg_t;

    localparam logic [SIZE_W-1:0] RST_CAMERA_WIDTH   = 12'd640;
    localparam logic [SIZE_W-1:0] RST_CAMERA_HEIGHT  = 12'd480;
    localparam logic [SIZE_W-1:0] RST_DISPLAY_WIDTH  = 12'd800;
    localparam logic [SIZE_W-1:0] RST_DISPLAY_HEIGHT = 12'd480;
    localparam logic [OFS_W-1:0]  RST_CHROMA_V_OFS   = 8'd18;

    // BT.601 fixed-point conversion, Q8 coefficients
    localparam int ACC_W = 21;
    localparam logic signed [ACC_W-1:0] C_Y    = 21'sd298;
    localparam logic signed [ACC_W-1:0] C_RV   = 21'sd409;
    localparam logic signed [ACC_W-1:0] C_GU   = 21'sd100;
    localparam logic signed [ACC_W-1:0] C_GV   = 21'sd208;
    localparam logic signed [ACC_W-1:0] C_BU   = 21'sd516;
    localparam logic signed [ACC_W-1:0] C_RND  = 21'sd128;
    localparam logic signed [8:0]       Y_OFS  = 9'sd16;
    localparam logic signed [9:0]       C_OFS  = 10'sd128;

endpackage

// ===== hw/rtl/yuyv_to_rgb565_crop_unit.sv =====
// Top level: YUYV pair to RGB565 converter with crop to the display window.
//
//  channel  dir  handshake              payload
//  s_       in   s_tvalid / s_tready    s_tdata: Y0, U, Y1, V; s_tuser: frame start
//  m_       out  m_tvalid / m_tready    m_tdata: pixel 0, pixel 1, display index
//  apb      in   psel/penable/pready    camera/display size, V offset
//
// One item per cycle sustained while the output is not stalled. Two
// register stages: the input register holds the pair with its placement
// (raster counters advance at accept), the result register holds the converted pixels.
// Pairs outside the crop window are consumed without a result.
// aresetn is synchronous; it clears both stages, the counters and the
// configuration. A stalled output only holds s_tready low once both
// stages are full.
module yuyv_to_rgb565_crop_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
    input  logic [y2r_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] frame_start
    input  logic                            s_tuser,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] first_pixel, [31:16] second_pixel, [53:32] pixel_index, [55:54] zero
    output logic [y2r_pkg::M_TDATA_W-1:0]   m_tdata,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [y2r_pkg::APB_AW-1:0]      paddr,
    input  logic [y2r_pkg::APB_DW-1:0]      pwdata,
    output logic [y2r_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    // limit compares need room for both the register and the maximum
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int LW  = (WW > y2r_pkg::SIZE_W) ? WW : y2r_pkg::SIZE_W;
    localparam int LH  = (HW > y2r_pkg::SIZE_W) ? HW : y2r_pkg::SIZE_W;
    localparam int PCW = $clog2(MAX_WIDTH) - 1;   // pair column
    localparam int RW  = $clog2(MAX_HEIGHT);      // row count
    localparam int IW  = y2r_pkg::IDX_W;

    // ---------------- configuration registers ----------------
    logic [y2r_pkg::SIZE_W-1:0] cam_w_reg, cam_h_reg, disp_w_reg, disp_h_reg;
    logic [y2r_pkg::OFS_W-1:0]  v_ofs_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_w_reg  <= y2r_pkg::RST_CAMERA_WIDTH;
            cam_h_reg  <= y2r_pkg::RST_CAMERA_HEIGHT;
            disp_w_reg <= y2r_pkg::RST_DISPLAY_WIDTH;
            disp_h_reg <= y2r_pkg::RST_DISPLAY_HEIGHT;
            v_ofs_reg  <= y2r_pkg::RST_CHROMA_V_OFS;
        end else if (cfg_wr) begin
            case (y2r_pkg::cfg_reg_t'(paddr[4:2]))
                y2r_pkg::REG_CAMERA_WIDTH:   cam_w_reg  <= pwdata[y2r_pkg::SIZE_W-1:0];
                y2r_pkg::REG_CAMERA_HEIGHT:  cam_h_reg  <= pwdata[y2r_pkg::SIZE_W-1:0];
                y2r_pkg::REG_DISPLAY_WIDTH:  disp_w_reg <= pwdata[y2r_pkg::SIZE_W-1:0];
                y2r_pkg::REG_DISPLAY_HEIGHT: disp_h_reg <= pwdata[y2r_pkg::SIZE_W-1:0];
                y2r_pkg::REG_CHROMA_V_OFS:   v_ofs_reg  <= pwdata[y2r_pkg::OFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (y2r_pkg::cfg_reg_t'(paddr[4:2]))
            y2r_pkg::REG_CAMERA_WIDTH:   prdata = y2r_pkg::APB_DW'(cam_w_reg);
            y2r_pkg::REG_CAMERA_HEIGHT:  prdata = y2r_pkg::APB_DW'(cam_h_reg);
            y2r_pkg::REG_DISPLAY_WIDTH:  prdata = y2r_pkg::APB_DW'(disp_w_reg);
            y2r_pkg::REG_DISPLAY_HEIGHT: prdata = y2r_pkg::APB_DW'(disp_h_reg);
            y2r_pkg::REG_CHROMA_V_OFS:   prdata = y2r_pkg::APB_DW'(v_ofs_reg);
            default:                     prdata = '0;
        endcase
    end

    // effective sizes: oversized registers act as the maximum
    logic [LW-1:0] cw, dw, mw;
    logic [LH-1:0] ch, dh, mh;

    assign cw = (LW'(cam_w_reg)  > LW'(MAX_WIDTH))  ? LW'(MAX_WIDTH)  : LW'(cam_w_reg);
    assign dw = (LW'(disp_w_reg) > LW'(MAX_WIDTH))  ? LW'(MAX_WIDTH)  : LW'(disp_w_reg);
    assign ch = (LH'(cam_h_reg)  > LH'(MAX_HEIGHT)) ? LH'(MAX_HEIGHT) : LH'(cam_h_reg);
    assign dh = (LH'(disp_h_reg) > LH'(MAX_HEIGHT)) ? LH'(MAX_HEIGHT) : LH'(disp_h_reg);
    assign mw = (cw < dw) ? cw : dw;
    assign mh = (ch < dh) ? ch : dh;

    // ---------------- handshake / stage advance ----------------
    logic v1_reg, v2_reg;
    logic adv1, adv2, s_acc;

    assign adv2     = !v2_reg || m_tready;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = v2_reg;

    // ---------------- raster counters ----------------
    logic [PCW-1:0] pcol_reg, pcol_next, pcol_cur;
    logic [RW-1:0]  row_reg, row_next, row_cur;
    logic [IW-1:0]  rsi_reg, rsi_next, rsi_cur;
    logic [LW:0]    col_ext;
    logic           row_end, frame_end, keep;

    // frame start clears the counters before this pair is placed
    assign pcol_cur  = s_tuser ? '0 : pcol_reg;
    assign row_cur   = s_tuser ? '0 : row_reg;
    assign rsi_cur   = s_tuser ? '0 : rsi_reg;

    assign col_ext   = (LW+1)'({pcol_cur, 1'b0});
    assign row_end   = (col_ext + (LW+1)'(2)) >= (LW+1)'(cw);
    assign frame_end = ((LH+1)'(row_cur) + (LH+1)'(1)) >= (LH+1)'(ch);
    assign keep      = (col_ext < (LW+1)'(mw)) && ((LH+1)'(row_cur) < (LH+1)'(mh));

    always_comb begin
        pcol_next = pcol_cur + PCW'(1);
        row_next  = row_cur;
        rsi_next  = rsi_cur;
        if (row_end) begin
            pcol_next = '0;
            if (frame_end) begin
                row_next = '0;
                rsi_next = '0;
            end else begin
                row_next = row_cur + RW'(1);
                rsi_next = rsi_cur + IW'(dw);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcol_reg <= '0;
            row_reg  <= '0;
            rsi_reg  <= '0;
        end else if (s_acc) begin
            pcol_reg <= pcol_next;
            row_reg  <= row_next;
            rsi_reg  <= rsi_next;
        end
    end

    // ---------------- input register ----------------
    logic [7:0]        y0_reg, y1_reg;
    logic signed [8:0] u_reg, u_next;
    logic signed [9:0] w_reg, w_next;
    logic [IW-1:0]     idx_reg, idx_next;

    assign u_next   = $signed({1'b0, s_tdata[15:8]}) - 9'sd128;
    // w = V - offset - 128, range -255..255
    assign w_next   = $signed({2'b00, s_tdata[31:24]})
                    - $signed({{2{v_ofs_reg[7]}}, v_ofs_reg}) - y2r_pkg::C_OFS;
    assign idx_next = rsi_cur + IW'(col_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= s_acc && keep;
        end
        if (s_acc && keep) begin
            y0_reg  <= s_tdata[7:0];
            y1_reg  <= s_tdata[23:16];
            u_reg   <= u_next;
            w_reg   <= w_next;
            idx_reg <= idx_next;
        end
    end

    // ---------------- conversion and result register ----------------
    logic [y2r_pkg::PIX_W-1:0]     pix0, pix1;
    logic [y2r_pkg::M_TDATA_W-1:0] m_data_reg;

    y2r_pixel_conv u_conv0 (
        .luma     (y0_reg),
        .chroma_u (u_reg),
        .chroma_w (w_reg),
        .rgb565   (pix0)
    );

    y2r_pixel_conv u_conv1 (
        .luma     (y1_reg),
        .chroma_u (u_reg),
        .chroma_w (w_reg),
        .rgb565   (pix1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
        if (adv2 && v1_reg) begin
            m_data_reg <= y2r_pkg::M_TDATA_W'({idx_reg, pix1, pix0});
        end
    end

    assign m_tdata = m_data_reg;

endmodule

// ===== hw/rtl/y2r_pixel_conv.sv =====
// One-pixel BT.601 YUV to RGB565 conversion with per-channel clamp.
module y2r_pixel_conv (
    input  logic [7:0]                 luma,
    input  logic signed [8:0]          chroma_u,
    input  logic signed [9:0]          chroma_w,
    output logic [y2r_pkg::PIX_W-1:0]  rgb565
);

    logic signed [8:0]                 y_s;
    logic signed [y2r_pkg::ACC_W-1:0]  acc_r;
    logic signed [y2r_pkg::ACC_W-1:0]  acc_g;
    logic signed [y2r_pkg::ACC_W-1:0]  acc_b;
    logic [7:0]                        r8;
    logic [7:0]                        g8;
    logic [7:0]                        b8;

    // floor shift by 8, then clamp to 0..255
    function automatic logic [7:0] clamp8(input logic signed [y2r_pkg::ACC_W-1:0] acc);
        logic [y2r_pkg::ACC_W-9:0] q;
        q = acc[y2r_pkg::ACC_W-1:8];
        if (q[y2r_pkg::ACC_W-9]) begin
            clamp8 = 8'd0;
        end else if (q[y2r_pkg::ACC_W-10:8] != '0) begin
            clamp8 = 8'hFF;
        end else begin
            clamp8 = q[7:0];
        end
    endfunction

    assign y_s   = $signed({1'b0, luma}) - y2r_pkg::Y_OFS;
    assign acc_r = y_s * y2r_pkg::C_Y + chroma_w * y2r_pkg::C_RV + y2r_pkg::C_RND;
    assign acc_g = y_s * y2r_pkg::C_Y - chroma_u * y2r_pkg::C_GU
                 - chroma_w * y2r_pkg::C_GV + y2r_pkg::C_RND;
    assign acc_b = y_s * y2r_pkg::C_Y + chroma_u * y2r_pkg::C_BU + y2r_pkg::C_RND;

    assign r8 = clamp8(acc_r);
    assign g8 = clamp8(acc_g);
    assign b8 = clamp8(acc_b);

    assign rgb565 = {r8[7:3], g8[7:2], b8[7:3]};

endmodule

// ===== hw/rtl/y2r_checker.sv =====
// Port-level checks for the YUYV to RGB565 crop unit, bound to the top level.
module y2r_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [y2r_pkg::M_TDATA_W-1:0]  m_tdata
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side only backs up when the output holds a result and stalls
    a_bp: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with room in the pipeline");

    // reset empties the result register
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // padding above the display index is zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[y2r_pkg::M_TDATA_W-1:y2r_pkg::M_TDATA_W-2] == 2'b00)
        else $error("result padding bits set");

endmodule

bind yuyv_to_rgb565_crop_unit y2r_checker u_y2r_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
